FILE: rtl/kcgr_pkg.sv
// Shared types and constants of the k-mer chaos game histogram.
package kcgr_pkg;

    localparam int COORD_W = 6;
    localparam int COUNT_W = 16;
    localparam int WL_W    = 3;

    localparam logic [WL_W-1:0]    WORD_LENGTH_RESET = 3'd6;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Control of one item travelling from the window stage to the count stage.
    typedef struct packed {
        logic valid;
        logic counted;
        logic is_read;
    } req_t;

endpackage

FILE: rtl/kmer_cgr_histogram.sv
// Top level of the k-mer chaos game histogram.
//
//   channel   handshake                 payload
//   -------   -----------------------   ------------------------------------------
//   command   start in, busy out        mode, base_char, read_x, read_y
//   result    done out (one cycle)      x_coord, y_coord, bin_count, counted
//   config    cfg_valid in, cfg_ready   word_length (k), always ready
//
// An item is accepted when start is high and busy is low; its result goes through
// the count stage and the result register to the done strobe. A new item may be
// accepted on every cycle while busy is low: the count memory is read in the
// accept cycle, incremented and written back in the next one, and a back-to-back
// hit on the same bin takes the value being written through a forwarding register.
// After reset the block clears the count memory, one entry per cycle, through all
// 2^(2*MAX_WORD_LENGTH) entries (4096 at the default); busy is high for that
// time and configuration writes are still taken. The receiver cannot stall
// the result strobe, so nothing ever holds the block off after the clear.
// Writing word_length empties the base window; the counts are kept.
module kmer_cgr_histogram #(
    parameter int MAX_WORD_LENGTH = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [7:0]                        base_char,
    input  logic [kcgr_pkg::COORD_W-1:0]      read_x,
    input  logic [kcgr_pkg::COORD_W-1:0]      read_y,
    output logic                              done,
    output logic [kcgr_pkg::COORD_W-1:0]      x_coord,
    output logic [kcgr_pkg::COORD_W-1:0]      y_coord,
    output logic [kcgr_pkg::COUNT_W-1:0]      bin_count,
    output logic                              counted,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kcgr_pkg::WL_W-1:0]         word_length
);

    localparam int MW    = MAX_WORD_LENGTH;
    localparam int EXT_W = kcgr_pkg::COORD_W + MW;

    kcgr_pkg::req_t req;
    logic [MW-1:0]  addr_x, addr_y;
    logic           clearing;
    logic           accept;
    logic [MW-1:0]  res_x, res_y;
    logic [EXT_W-1:0] res_x_ext, res_y_ext;

    // Configuration is always taken; the window clears on a write.
    assign cfg_ready = 1'b1;
    assign busy      = clearing;
    assign accept    = start && !clearing;

    kcgr_window #(
        .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
    ) u_window (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_valid),
        .cfg_word_length (word_length),
        .accept          (accept),
        .mode            (mode),
        .base_char       (base_char),
        .read_x          (read_x),
        .read_y          (read_y),
        .req             (req),
        .addr_x          (addr_x),
        .addr_y          (addr_y)
    );

    kcgr_counter #(
        .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
    ) u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .addr_x      (addr_x),
        .addr_y      (addr_y),
        .clearing    (clearing),
        .res_valid   (done),
        .res_counted (counted),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_count   (bin_count)
    );

    // Coordinates are carried at the window width and shown on 6-bit ports.
    assign res_x_ext = EXT_W'(res_x);
    assign res_y_ext = EXT_W'(res_y);
    assign x_coord   = res_x_ext[kcgr_pkg::COORD_W-1:0];
    assign y_coord   = res_y_ext[kcgr_pkg::COORD_W-1:0];

endmodule

FILE: rtl/kcgr_window.sv
// Base decoder, sliding k-base window and bin address selection.
module kcgr_window #(
    parameter int MAX_WORD_LENGTH = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kcgr_pkg::WL_W-1:0]      cfg_word_length,
    input  logic                           accept,
    input  logic                           mode,
    input  logic [7:0]                     base_char,
    input  logic [kcgr_pkg::COORD_W-1:0]   read_x,
    input  logic [kcgr_pkg::COORD_W-1:0]   read_y,
    output kcgr_pkg::req_t                 req,
    output logic [MAX_WORD_LENGTH-1:0]     addr_x,
    output logic [MAX_WORD_LENGTH-1:0]     addr_y
);

    localparam int MW    = MAX_WORD_LENGTH;
    localparam int EXT_W = kcgr_pkg::COORD_W + MW;

    logic [kcgr_pkg::WL_W-1:0] word_length_reg;
    logic [MW-1:0]             win_x_reg, win_x_next;
    logic [MW-1:0]             win_y_reg, win_y_next;
    logic [kcgr_pkg::WL_W-1:0] seen_reg, seen_next;

    logic [kcgr_pkg::WL_W:0]   wl_wide;
    logic [kcgr_pkg::WL_W-1:0] k_eff;
    logic [MW-1:0]             kmask;
    logic                      base_ok, bx, by;
    logic [EXT_W-1:0]          rx_ext, ry_ext;
    logic [MW-1:0]             rx, ry;
    logic                      push_ok;

    // Out-of-range word lengths clamp to one and to the maximum.
    always_comb
    begin
        wl_wide = {1'b0, word_length_reg};
        if (word_length_reg == '0)
            k_eff = kcgr_pkg::WL_W'(1);
        else if (wl_wide > (kcgr_pkg::WL_W + 1)'(MW))
            k_eff = kcgr_pkg::WL_W'(MW);
        else
            k_eff = word_length_reg;
        for (int i = 0; i < MW; i++)
            kmask[i] = ((kcgr_pkg::WL_W + 1)'(i) < {1'b0, k_eff});
    end

    always_comb
    begin
        base_ok = 1'b1;
        bx      = 1'b0;
        by      = 1'b0;
        case (base_char)
            kcgr_pkg::CHAR_A: begin bx = 1'b0; by = 1'b0; end
            kcgr_pkg::CHAR_C: begin bx = 1'b0; by = 1'b1; end
            kcgr_pkg::CHAR_G: begin bx = 1'b1; by = 1'b0; end
            kcgr_pkg::CHAR_T: begin bx = 1'b1; by = 1'b1; end
            default:          base_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        win_x_next = ((win_x_reg << 1) | MW'(bx)) & kmask;
        win_y_next = ((win_y_reg << 1) | MW'(by)) & kmask;
        if (seen_reg < k_eff)
            seen_next = seen_reg + kcgr_pkg::WL_W'(1);
        else
            seen_next = seen_reg;
        push_ok = accept && (mode == kcgr_pkg::MODE_PUSH) && base_ok;

        rx_ext = EXT_W'(read_x);
        ry_ext = EXT_W'(read_y);
        rx     = rx_ext[MW-1:0] & kmask;
        ry     = ry_ext[MW-1:0] & kmask;
    end

    always_comb
    begin
        req.valid   = accept;
        req.is_read = (mode == kcgr_pkg::MODE_READ);
        req.counted = req.is_read || (base_ok && (seen_next == k_eff));
        addr_x      = req.is_read ? rx : win_x_next;
        addr_y      = req.is_read ? ry : win_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg <= kcgr_pkg::WORD_LENGTH_RESET;
            win_x_reg       <= '0;
            win_y_reg       <= '0;
            seen_reg        <= '0;
        end
        else if (cfg_we)
        begin
            word_length_reg <= cfg_word_length;
            win_x_reg       <= '0;
            win_y_reg       <= '0;
            seen_reg        <= '0;
        end
        else if (push_ok)
        begin
            win_x_reg <= win_x_next;
            win_y_reg <= win_y_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

FILE: rtl/kcgr_counter.sv
// Count memory with clearing pass and forwarded read-modify-write.
module kcgr_counter #(
    parameter int MAX_WORD_LENGTH = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  kcgr_pkg::req_t                   req,
    input  logic [MAX_WORD_LENGTH-1:0]       addr_x,
    input  logic [MAX_WORD_LENGTH-1:0]       addr_y,
    output logic                             clearing,
    output logic                             res_valid,
    output logic                             res_counted,
    output logic [MAX_WORD_LENGTH-1:0]       res_x,
    output logic [MAX_WORD_LENGTH-1:0]       res_y,
    output logic [kcgr_pkg::COUNT_W-1:0]     res_count
);

    localparam int MW    = MAX_WORD_LENGTH;
    localparam int AW    = 2 * MW;
    localparam int DEPTH = 1 << AW;

    logic [kcgr_pkg::COUNT_W-1:0] mem [DEPTH];

    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    // Count stage: the memory word read for the item accepted last cycle.
    logic                         s1_valid_reg, s1_counted_reg, s1_read_reg;
    logic [MW-1:0]                s1_x_reg, s1_y_reg;
    logic [kcgr_pkg::COUNT_W-1:0] rd_data_reg;

    logic                         wr_valid_reg;
    logic [AW-1:0]                wr_addr_reg;
    logic [kcgr_pkg::COUNT_W-1:0] wr_data_reg;

    logic                         res_valid_reg, res_counted_reg;
    logic [MW-1:0]                res_x_reg, res_y_reg;
    logic [kcgr_pkg::COUNT_W-1:0] res_count_reg;

    logic [AW-1:0]                s1_addr;
    logic [kcgr_pkg::COUNT_W-1:0] cur_count, inc_count;
    logic                         do_write;

    // The write of the previous item lands after this item's read was issued,
    // so a matching address takes the written value instead.
    always_comb
    begin
        s1_addr   = {s1_x_reg, s1_y_reg};
        cur_count = (wr_valid_reg && (wr_addr_reg == s1_addr)) ? wr_data_reg : rd_data_reg;
        inc_count = (cur_count == kcgr_pkg::COUNT_MAX) ? cur_count
                                                       : cur_count + kcgr_pkg::COUNT_W'(1);
        do_write  = s1_valid_reg && s1_counted_reg && !s1_read_reg;
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_addr_reg] <= '0;
        else if (do_write)
            mem[s1_addr] <= inc_count;
        if (req.valid)
            rd_data_reg <= mem[{addr_x, addr_y}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            wr_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == {AW{1'b1}})
                    clearing_reg <= 1'b0;
            end
            s1_valid_reg  <= req.valid;
            wr_valid_reg  <= do_write;
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            s1_counted_reg <= req.counted;
            s1_read_reg    <= req.is_read;
            s1_x_reg       <= addr_x;
            s1_y_reg       <= addr_y;
        end
        wr_addr_reg <= s1_addr;
        wr_data_reg <= inc_count;
        if (s1_valid_reg)
        begin
            res_counted_reg <= s1_counted_reg;
            res_x_reg       <= s1_counted_reg ? s1_x_reg : '0;
            res_y_reg       <= s1_counted_reg ? s1_y_reg : '0;
            if (!s1_counted_reg)
                res_count_reg <= '0;
            else if (s1_read_reg)
                res_count_reg <= cur_count;
            else
                res_count_reg <= inc_count;
        end
    end

    assign clearing    = clearing_reg;
    assign res_valid   = res_valid_reg;
    assign res_counted = res_counted_reg;
    assign res_x       = res_x_reg;
    assign res_y       = res_y_reg;
    assign res_count   = res_count_reg;

endmodule

FILE: rtl/kcgr_checker.sv
// Port-level checker of the k-mer chaos game histogram and its bind.
module kcgr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          mode,
    input  logic                          done,
    input  logic [kcgr_pkg::COORD_W-1:0]  x_coord,
    input  logic [kcgr_pkg::COORD_W-1:0]  y_coord,
    input  logic [kcgr_pkg::COUNT_W-1:0]  bin_count,
    input  logic                          counted
);

    // Every accepted item gives exactly one result on done.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && !busy, 2) |-> done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted item");

    // A result that counted nothing carries all-zero fields.
    a_uncounted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !counted) |-> (bin_count == '0 && x_coord == '0 && y_coord == '0))
        else $error("uncounted result carries nonzero fields");

    // A counted push never reports an empty bin.
    a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && counted && $past(mode, 2) == kcgr_pkg::MODE_PUSH) |-> (bin_count != '0))
        else $error("counted push reported a zero count");

    // The clearing pass runs once after reset.
    a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose again after the clearing pass");

endmodule

bind kmer_cgr_histogram kcgr_checker u_kcgr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .done      (done),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .bin_count (bin_count),
    .counted   (counted)
);

FILE: tb/bin_count_checker.sv
// Checker that predicts and compares the results of the k-mer chaos game histogram.
`timescale 1ns / 100ps

module bin_count_checker
    import kcgr_pkg::*;
#(
    parameter int MAX_WORD_LENGTH = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               mode,
    input  logic [7:0]         base_char,
    input  logic [COORD_W-1:0] read_x,
    input  logic [COORD_W-1:0] read_y,
    input  logic               done,
    input  logic [COORD_W-1:0] x_coord,
    input  logic [COORD_W-1:0] y_coord,
    input  logic [COUNT_W-1:0] bin_count,
    input  logic               counted,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [WL_W-1:0]    word_length,
    output int                 failures,
    output int                 outstanding,
    output int                 results_checked
);

    localparam int STORE_DEPTH = 1 << (2 * MAX_WORD_LENGTH);

    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic [COUNT_W-1:0] bin_count;
        logic               counted;
    } bin_result_t;

    logic [WL_W-1:0]    word_len_reg;
    logic [COORD_W-1:0] window_x;
    logic [COORD_W-1:0] window_y;
    int                 bases_held;
    logic [COUNT_W-1:0] bin_counts [STORE_DEPTH];
    bin_result_t        expected_bins [$];

    task automatic report_error(input string msg);
        $display("%0t ns: checker: %s", $time, msg);
        failures++;
    endtask

    // Out-of-range word lengths are clamped into 1..MAX_WORD_LENGTH.
    function automatic int active_k();
        int k;
        k = int'(word_len_reg);
        if (k == 0)
            k = 1;
        if (k > MAX_WORD_LENGTH)
            k = MAX_WORD_LENGTH;
        return k;
    endfunction

    task automatic predict_bin(input logic m, input logic [7:0] ch,
                               input logic [COORD_W-1:0] rx, input logic [COORD_W-1:0] ry);
        bin_result_t        want;
        int                 k;
        int                 addr;
        logic [COORD_W-1:0] kmask;
        logic               bx;
        logic               by;
        logic               is_base;
        k     = active_k();
        kmask = COORD_W'((1 << k) - 1);
        want  = '0;
        bx    = 1'b0;
        by    = 1'b0;
        if (m == MODE_READ) begin
            want.x_coord   = rx & kmask;
            want.y_coord   = ry & kmask;
            addr           = (int'(want.x_coord) << MAX_WORD_LENGTH) | int'(want.y_coord);
            want.bin_count = bin_counts[addr];
            want.counted   = 1'b1;
        end else begin
            is_base = 1'b1;
            case (ch)
                CHAR_A: {bx, by} = 2'b00;
                CHAR_C: {bx, by} = 2'b01;
                CHAR_G: {bx, by} = 2'b10;
                CHAR_T: {bx, by} = 2'b11;
                default: is_base = 1'b0;
            endcase
            if (is_base) begin
                window_x = ((window_x << 1) | COORD_W'(bx)) & kmask;
                window_y = ((window_y << 1) | COORD_W'(by)) & kmask;
                if (bases_held < k)
                    bases_held++;
                if (bases_held >= k) begin
                    addr = (int'(window_x) << MAX_WORD_LENGTH) | int'(window_y);
                    if (bin_counts[addr] != COUNT_MAX)
                        bin_counts[addr] = bin_counts[addr] + 1'b1;
                    want.x_coord   = window_x;
                    want.y_coord   = window_y;
                    want.bin_count = bin_counts[addr];
                    want.counted   = 1'b1;
                end
            end
        end
        expected_bins.push_back(want);
    endtask

    always @(posedge clk or negedge rst_n) begin
        bin_result_t want;
        if (!rst_n) begin
            word_len_reg = WORD_LENGTH_RESET;
            window_x     = '0;
            window_y     = '0;
            bases_held   = 0;
            for (int i = 0; i < STORE_DEPTH; i++)
                bin_counts[i] = '0;
            expected_bins.delete();
            outstanding = 0;
        end else begin
            if (done) begin
                if (expected_bins.size() == 0) begin
                    report_error($sformatf("result with nothing outstanding: x %0d y %0d count %0d",
                                           x_coord, y_coord, bin_count));
                end else begin
                    want = expected_bins.pop_front();
                    if (x_coord !== want.x_coord)
                        report_error($sformatf("x_coord %0d, expected %0d",
                                               x_coord, want.x_coord));
                    if (y_coord !== want.y_coord)
                        report_error($sformatf("y_coord %0d, expected %0d",
                                               y_coord, want.y_coord));
                    if (bin_count !== want.bin_count)
                        report_error($sformatf("bin_count %0d, expected %0d",
                                               bin_count, want.bin_count));
                    if (counted !== want.counted)
                        report_error($sformatf("counted %0b, expected %0b",
                                               counted, want.counted));
                    results_checked++;
                end
            end
            if (start && !busy)
                predict_bin(mode, base_char, read_x, read_y);
            // A word length write empties the window but keeps the counts.
            if (cfg_valid && cfg_ready) begin
                word_len_reg = word_length;
                window_x     = '0;
                window_y     = '0;
                bases_held   = 0;
            end
            outstanding = expected_bins.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Top level of the testbench for the k-mer chaos game histogram.
`timescale 1ns / 100ps

module testbench;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         mode;
    logic [7:0]                   base_char;
    logic [kcgr_pkg::COORD_W-1:0] read_x;
    logic [kcgr_pkg::COORD_W-1:0] read_y;
    logic                         done;
    logic [kcgr_pkg::COORD_W-1:0] x_coord;
    logic [kcgr_pkg::COORD_W-1:0] y_coord;
    logic [kcgr_pkg::COUNT_W-1:0] bin_count;
    logic                         counted;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [kcgr_pkg::WL_W-1:0]    word_length;

    int failures;
    int outstanding;
    int results_checked;

    // Stimulus bookkeeping for the closing summary.
    int idle_pct;
    int items_sent;
    int reads_sent;
    int repeat_pushes;
    int k_writes;

    // Word lengths visited by the random phases; 0 and 7 are out of range and
    // get clamped by the block. The reset value 6 is used by the directed part.
    logic [kcgr_pkg::WL_W-1:0] k_plan [8] = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};

    // Sender idle percentage, cycled across the phases. The receiver cannot
    // hold results off, so only the sender side ever idles.
    int idle_plan [3] = '{0, 75, 33};

    kmer_cgr_histogram dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .base_char   (base_char),
        .read_x      (read_x),
        .read_y      (read_y),
        .done        (done),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .bin_count   (bin_count),
        .counted     (counted),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .word_length (word_length)
    );

    bin_count_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .base_char       (base_char),
        .read_x          (read_x),
        .read_y          (read_y),
        .done            (done),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .bin_count       (bin_count),
        .counted         (counted),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .word_length     (word_length),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // 4 ns clock period.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sends one item. Before it, the sender may idle for a random number of
    // cycles; while idle, the payload ports carry junk that the block must
    // ignore. The item is then presented at a falling edge and held until a
    // rising edge finds busy low. Start stays high afterwards, so back-to-back
    // items never see start dropped and raised within one time step.
    task automatic send_item(input logic m, input logic [7:0] ch,
                             input logic [kcgr_pkg::COORD_W-1:0] rx,
                             input logic [kcgr_pkg::COORD_W-1:0] ry);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start     = 1'b0;
            mode      = 1'($urandom);
            base_char = 8'($urandom);
        end
        @(negedge clk);
        start     = 1'b1;
        mode      = m;
        base_char = ch;
        read_x    = rx;
        read_y    = ry;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (m == kcgr_pkg::MODE_READ)
            reads_sent++;
    endtask

    // Mostly well-formed bases so that the window fills and words get
    // counted, with a share of bin reads and a share of arbitrary character
    // codes as noise.
    task automatic send_random_item();
        int         pick;
        logic [7:0] ch;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            send_item(kcgr_pkg::MODE_READ, 8'($urandom), kcgr_pkg::COORD_W'($urandom),
                      kcgr_pkg::COORD_W'($urandom));
        end
        else
        begin
            if (pick < 32)
                ch = 8'($urandom);
            else
            begin
                case ($urandom_range(0, 3))
                    0: ch = kcgr_pkg::CHAR_A;
                    1: ch = kcgr_pkg::CHAR_C;
                    2: ch = kcgr_pkg::CHAR_G;
                    default: ch = kcgr_pkg::CHAR_T;
                endcase
            end
            send_item(kcgr_pkg::MODE_PUSH, ch, kcgr_pkg::COORD_W'($urandom),
                      kcgr_pkg::COORD_W'($urandom));
        end
    endtask

    // Drops start and waits until every expected result has come back, then
    // lets a few more cycles pass so that the block is surely idle.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Writes word_length; only called while the block is idle.
    task automatic write_word_length(input logic [kcgr_pkg::WL_W-1:0] value);
        @(negedge clk);
        cfg_valid   = 1'b1;
        word_length = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        k_writes++;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = kcgr_pkg::MODE_PUSH;
        base_char   = 8'h00;
        read_x      = '0;
        read_y      = '0;
        cfg_valid   = 1'b0;
        word_length = kcgr_pkg::WORD_LENGTH_RESET;
        idle_pct    = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset word length of 6. The first item waits
        // out the memory clear that follows reset. Reads of the cleared store
        // come first, at both corners of the coordinate range.
        send_item(kcgr_pkg::MODE_READ, kcgr_pkg::CHAR_A, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_READ, kcgr_pkg::CHAR_T, 6'd63, 6'd63);
        // Five bases only partly fill the window, so nothing is counted yet.
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_A, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_C, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_G, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_T, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_A, 6'd0, 6'd0);
        // Lower case and other codes are ignored and do not shift the window.
        send_item(kcgr_pkg::MODE_PUSH, 8'h61, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, 8'h00, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, 8'hFF, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, 8'h74, 6'd0, 6'd0);
        // The sixth base completes ACGTAC, which lands at x 12, y 21.
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_C, 6'd63, 6'd63);
        send_item(kcgr_pkg::MODE_READ, kcgr_pkg::CHAR_G, 6'd12, 6'd21);
        // Every further base is counted, including repeats of one bin.
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_T, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_T, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_T, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_T, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_T, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_T, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_T, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_G, 6'd0, 6'd0);
        send_item(kcgr_pkg::MODE_READ, kcgr_pkg::CHAR_A, 6'd63, 6'd63);
        drain();

        // Random phases, one per word length, with the idle percentage cycled across them.
        foreach (k_plan[p])
        begin
            write_word_length(k_plan[p]);
            idle_pct = idle_plan[p % 3];
            repeat (150) send_random_item();
            drain();
        end

        // At word length 1 every A lands in bin (0, 0), so a burst of them
        // hits one bin back to back through the forwarding path.
        write_word_length(3'd1);
        idle_pct = 0;
        repeat (20)
        begin
            send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_A, 6'd0, 6'd0);
            repeat_pushes++;
        end
        send_item(kcgr_pkg::MODE_READ, kcgr_pkg::CHAR_C, 6'd0, 6'd0);
        // Coordinates above 1 wrap to their low bit at this word length.
        send_item(kcgr_pkg::MODE_READ, kcgr_pkg::CHAR_T, 6'd62, 6'd63);
        send_item(kcgr_pkg::MODE_PUSH, kcgr_pkg::CHAR_A, 6'd0, 6'd0);
        drain();

        $display("run covered %0d items, %0d of them bin reads, %0d same-bin pushes",
                 items_sent, reads_sent, repeat_pushes);
        $display("%0d word length writes spanning 0..7, %0d results checked, %0d failures",
                 k_writes, results_checked, failures);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
